[rtl/bis_pkg.sv]
// Shared types and constants for the bounded integer set table.
`default_nettype none

package bis_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int RSP_COUNT_W  = 5;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_REMOVE = 2'd3
   } bis_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_MOVE,
      ST_RESP
   } bis_state_type;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [VALUE_W-1:0] value;
   } bis_req_type;

   typedef struct packed {
      logic                   ok;
      logic [RSP_COUNT_W-1:0] count;
   } bis_rsp_type;

   typedef struct packed {
      logic done;
      logic ok;
   } bis_res_type;

endpackage

`default_nettype wire

[rtl/bounded_integer_set_table_top.sv]
// Top level of the bounded integer set table: sequencer, element RAM, result register.
// A clear finishes without a search; lookup, insert and remove scan the held elements,
// and a successful remove then moves the last element into the freed slot.
// Requests are stalled until the previous one is done; the search reads one RAM entry a cycle.
// A finished result waits in the result register while the next request is taken.
// Reset empties the set at once; the element RAM is not cleared.
`default_nettype none

module bounded_integer_set_table_top import bis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire bis_req_type req,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output bis_rsp_type      rsp
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                idle;
   logic                res_take;
   bis_res_type         res;
   logic [CNT_W-1:0]    count;
   logic [CNT_W+RSP_COUNT_W-1:0] count_ext;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   logic                rsp_valid_ff;
   bis_rsp_type         rsp_ff;

   bis_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .idle      (idle),
      .res_take  (res_take),
      .res       (res),
      .count     (count),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bis_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = !idle;
   assign res_take  = !rsp_valid_ff || !rsp_stall;
   assign count_ext = {{RSP_COUNT_W{1'b0}}, count};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.done && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.done && res_take) begin
         rsp_ff.ok    <= res.ok;
         rsp_ff.count <= count_ext[RSP_COUNT_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

[rtl/bis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/bis_ctrl.sv]
// Sequencer: linear search with one shared compare, insert and swap-remove.
`default_nettype none

module bis_ctrl import bis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire bis_req_type        req,
   output logic                    idle,
   input  wire logic               res_take,
   output bis_res_type             res,
   output logic [CNT_W-1:0]        count,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output logic [VALUE_W-1:0]      wr_data,
   output logic                    rd_en,
   output logic [IDX_W-1:0]        rd_addr,
   input  wire logic [VALUE_W-1:0] rd_data
);

   bis_state_type       state_ff, state_in;
   bis_cmd_type         cmd_ff, cmd_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ok_ff, ok_in;

   logic                hit;
   logic                scan_more;
   logic                full;
   logic [CNT_W-1:0]    count_dec;

   assign hit       = cmp_vld_ff && (rd_data == value_ff);
   assign scan_more = rd_idx_ff < count_ff;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign count_dec = count_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff    <= slot_in;
      ok_ff      <= ok_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      ok_in      = ok_ff;
      rd_en      = 1'b0;
      rd_addr    = rd_idx_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = value_ff;
      res.done   = 1'b0;
      res.ok     = ok_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = bis_cmd_type'(req.cmd);
               value_in   = req.value;
               rd_idx_in  = '0;
               cmp_vld_in = 1'b0;
               if (bis_cmd_type'(req.cmd) == CMD_CLEAR) begin
                  count_in = '0;
                  ok_in    = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en      = scan_more;
            cmp_vld_in = scan_more;
            cmp_idx_in = rd_idx_ff[IDX_W-1:0];
            if (scan_more) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (hit) begin
               cmp_vld_in = 1'b0;
               case (cmd_ff)
                  CMD_REMOVE: begin
                     slot_in  = cmp_idx_ff;
                     state_in = ST_LAST;
                  end
                  CMD_INSERT: begin
                     ok_in    = 1'b0;
                     state_in = ST_RESP;
                  end
                  default: begin
                     ok_in    = 1'b1;
                     state_in = ST_RESP;
                  end
               endcase
            end else if (!scan_more) begin
               cmp_vld_in = 1'b0;
               state_in   = ST_RESP;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (!full) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        ok_in    = 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_LAST: begin
            rd_en    = 1'b1;
            rd_addr  = count_dec[IDX_W-1:0];
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            count_in = count_dec;
            ok_in    = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            res.done = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle  = state_ff == ST_IDLE;
   assign count = count_ff;

endmodule

`default_nettype wire

[rtl/bis_checker.sv]
// Port-level checks for the bounded integer set table, bound to the top level.
`default_nettype none

module bis_checker import bis_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire bis_req_type req,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire bis_rsp_type rsp
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result dropped or changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 31) || (int'(rsp.count) <= CAPACITY))
      else $error("result count above capacity");

endmodule

bind bounded_integer_set_table_top bis_checker #(.CAPACITY(CAPACITY)) u_bis_checker (.*);

`default_nettype wire
